/* rtl/assert_macros.svh */
// assertion macros shared by the checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// property that must hold at every clock edge outside reset
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// same, sampled with reset not masked
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);
`endif

/* rtl/pwl_pkg.sv */
// ----------------------------------------------------------------------------
// pwl_pkg
// shared types and codes of the piecewise linear lookup table
// ----------------------------------------------------------------------------
package pwl_pkg;
	typedef enum logic [1:0] {
		CMD_CLEAR  = 2'd0,
		CMD_INSERT = 2'd1,
		CMD_QUERY  = 2'd2,
		CMD_NOP    = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_DUP   = 2'd1,
		ST_FULL  = 2'd2,
		ST_EMPTY = 2'd3
	} status_t;

	typedef enum logic [3:0] {
		BK_IDLE,
		BK_SCAN_RD,
		BK_SCAN_CHK,
		BK_SHIFT_RD,
		BK_SHIFT_WR,
		BK_WRITE,
		BK_NB_RD,
		BK_NB_WAIT,
		BK_DIV,
		BK_MUL_HI,
		BK_MUL_LO,
		BK_ADD,
		BK_OUT
	} bk_state_t;

	localparam int unsigned FRAC_BITS = 16;
	localparam int unsigned STAT_W    = 2;
	localparam int unsigned CNT_W     = 7;
	localparam int unsigned QUEUE_DEPTH = 2;
endpackage

/* rtl/pwl_ram.sv */
// ----------------------------------------------------------------------------
// pwl_ram
// generic single port ram with registered read
// ----------------------------------------------------------------------------
module pwl_ram #(
	parameter int unsigned WIDTH = 32,
	parameter int unsigned DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata <= mem_q[addr];
	end
endmodule

/* rtl/pwl_front.sv */
// ----------------------------------------------------------------------------
// pwl_front
// accepts commands, decodes them and holds them in a short queue
// ----------------------------------------------------------------------------
module pwl_front
	import pwl_pkg::*;
#(
	parameter int unsigned TIME_WIDTH  = 32,
	parameter int unsigned VALUE_WIDTH = 32
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  logic [1:0]             cmd,
	input  logic [TIME_WIDTH-1:0]  key_time,
	input  logic [VALUE_WIDTH-1:0] point_value,
	output logic                   q_valid,
	input  logic                   q_pop,
	output cmd_t                   q_cmd,
	output logic [TIME_WIDTH-1:0]  q_time,
	output logic [VALUE_WIDTH-1:0] q_value
);
	localparam int unsigned PW = $clog2(QUEUE_DEPTH);

	cmd_t                   cmd_q   [QUEUE_DEPTH];
	logic [TIME_WIDTH-1:0]  time_q  [QUEUE_DEPTH];
	logic [VALUE_WIDTH-1:0] value_q [QUEUE_DEPTH];
	logic [PW-1:0]          wr_q, rd_q;
	logic [PW:0]            fill_q;
	logic                   push;

	assign in_ready = (fill_q != (PW+1)'(QUEUE_DEPTH));
	assign push     = in_valid && in_ready;
	assign q_valid  = (fill_q != '0);
	assign q_cmd    = cmd_q[rd_q];
	assign q_time   = time_q[rd_q];
	assign q_value  = value_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			cmd_q[wr_q]   <= cmd_t'(cmd);
			time_q[wr_q]  <= key_time;
			value_q[wr_q] <= point_value;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q   <= '0;
			rd_q   <= '0;
			fill_q <= '0;
		end else begin
			if (push) wr_q <= wr_q + PW'(1);
			if (q_pop) rd_q <= rd_q + PW'(1);
			fill_q <= fill_q + (PW+1)'(push) - (PW+1)'(q_pop);
		end
	end
endmodule

/* rtl/pwl_back.sv */
// ----------------------------------------------------------------------------
// pwl_back
// table search, insertion shift, fraction divide and interpolation
// ----------------------------------------------------------------------------
module pwl_back
	import pwl_pkg::*;
#(
	parameter int unsigned TABLE_DEPTH = 64,
	parameter int unsigned TIME_WIDTH  = 32,
	parameter int unsigned VALUE_WIDTH = 32
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   q_valid,
	output logic                   q_pop,
	input  cmd_t                   q_cmd,
	input  logic [TIME_WIDTH-1:0]  q_time,
	input  logic [VALUE_WIDTH-1:0] q_value,
	output logic                   out_valid,
	input  logic                   out_ready,
	output logic [VALUE_WIDTH-1:0] result_value,
	output logic [STAT_W-1:0]      status,
	output logic [CNT_W-1:0]       entry_count
);
	localparam int unsigned AW = $clog2(TABLE_DEPTH);
	localparam int unsigned NW = $clog2(TABLE_DEPTH + 1);
	localparam int unsigned DW = TIME_WIDTH + 1;
	localparam int unsigned MW = VALUE_WIDTH + 1;

	bk_state_t state_q, state_d;
	logic [NW-1:0] used_q, idx_q, pos_q;
	logic [4:0]    step_q;

	// table memories
	logic           we;
	logic [AW-1:0]  addr;
	logic [TIME_WIDTH-1:0]  t_wd, t_rd;
	logic [VALUE_WIDTH-1:0] v_wd, v_rd;

	pwl_ram #(.WIDTH(TIME_WIDTH), .DEPTH(TABLE_DEPTH)) u_tram (
		.clk(clk), .we(we), .addr(addr), .wdata(t_wd), .rdata(t_rd));
	pwl_ram #(.WIDTH(VALUE_WIDTH), .DEPTH(TABLE_DEPTH)) u_vram (
		.clk(clk), .we(we), .addr(addr), .wdata(v_wd), .rdata(v_rd));

	// working registers
	cmd_t                   cmd_q;
	logic [TIME_WIDTH-1:0]  tq_q;
	logic [VALUE_WIDTH-1:0] vq_q;
	logic signed [TIME_WIDTH-1:0]  t1_q;
	logic signed [VALUE_WIDTH-1:0] v0_q, v1_q;
	logic [DW-1:0]  num_q, den_q;
	logic [FRAC_BITS:0] f_q;
	logic           neg_q;
	logic [MW-1:0]  mag_q;
	logic [MW+FRAC_BITS:0] phi_q, plo_q;
	logic [VALUE_WIDTH-1:0] res_q;
	logic [STAT_W-1:0]      stat_q;
	logic           ov_q;

	logic signed [TIME_WIDTH-1:0] tq_s, trd_s;
	logic [DW:0] rsh;
	assign tq_s  = signed'(tq_q);
	assign trd_s = signed'(t_rd);
	assign rsh   = {num_q, 1'b0};

	assign out_valid    = ov_q;
	assign result_value = res_q;
	assign status       = stat_q;
	assign entry_count  = CNT_W'(used_q);

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= BK_IDLE;
		else         state_q <= state_d;
	end

	// next state and memory controls
	always_comb begin
		state_d = state_q;
		q_pop   = 1'b0;
		we      = 1'b0;
		addr    = AW'(idx_q);
		t_wd    = t_rd;
		v_wd    = v_rd;
		unique case (state_q)
			BK_IDLE: begin
				if (q_valid && !ov_q) begin
					q_pop = 1'b1;
					priority if (q_cmd == CMD_INSERT || q_cmd == CMD_QUERY) begin
						if (used_q == '0) state_d = (q_cmd == CMD_INSERT) ? BK_WRITE : BK_OUT;
						else              state_d = BK_SCAN_RD;
					end else state_d = BK_OUT;
				end
			end
			BK_SCAN_RD:  state_d = BK_SCAN_CHK;
			BK_SCAN_CHK: begin
				if (idx_q < used_q && trd_s < tq_s) state_d = BK_SCAN_RD;
				else if (cmd_q == CMD_QUERY) begin
					// past the last key the last entry is read back through the ram
					if (idx_q == '0) state_d = BK_OUT;
					else state_d = BK_NB_RD;
				end else if (idx_q < used_q && trd_s == tq_s) state_d = BK_OUT;
				else if (used_q >= NW'(TABLE_DEPTH)) state_d = BK_OUT;
				else state_d = (used_q == idx_q) ? BK_WRITE : BK_SHIFT_RD;
			end
			BK_SHIFT_RD: state_d = BK_SHIFT_WR;
			BK_SHIFT_WR: begin
				we    = 1'b1;
				addr  = AW'(idx_q + NW'(1));
				state_d = (idx_q == pos_q) ? BK_WRITE : BK_SHIFT_RD;
			end
			BK_WRITE: begin
				we   = 1'b1;
				addr = AW'(pos_q);
				t_wd = tq_q;
				v_wd = vq_q;
				state_d = BK_OUT;
			end
			BK_NB_RD:   state_d = BK_NB_WAIT;
			BK_NB_WAIT: state_d = (pos_q >= used_q) ? BK_OUT : BK_DIV;
			BK_DIV:     if (step_q == 5'd16) state_d = BK_MUL_HI;
			BK_MUL_HI:  state_d = BK_MUL_LO;
			BK_MUL_LO:  state_d = BK_ADD;
			BK_ADD:     state_d = BK_OUT;
			BK_OUT:     state_d = BK_IDLE;
			default:    state_d = BK_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q <= '0;
			ov_q   <= 1'b0;
		end else begin
			if (state_q == BK_OUT) ov_q <= 1'b1;
			else if (out_ready) ov_q <= 1'b0;
			if (state_q == BK_IDLE && q_pop && q_cmd == CMD_CLEAR) used_q <= '0;
			else if (state_q == BK_WRITE) used_q <= used_q + NW'(1);
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		unique case (state_q)
			BK_IDLE: begin
				if (q_pop) begin
					cmd_q  <= q_cmd;
					tq_q   <= q_time;
					vq_q   <= q_value;
					idx_q  <= '0;
					pos_q  <= '0;
					res_q  <= '0;
					stat_q <= (q_cmd == CMD_QUERY && used_q == '0) ? ST_EMPTY : ST_OK;
				end
			end
			BK_SCAN_CHK: begin
				if (idx_q < used_q && trd_s < tq_s) idx_q <= idx_q + NW'(1);
				else begin
					pos_q <= idx_q;
					t1_q  <= trd_s;
					v1_q  <= signed'(v_rd);
					if (cmd_q == CMD_QUERY) begin
						if (idx_q == '0) res_q <= v_rd;
						else if (idx_q >= used_q) idx_q <= used_q - NW'(1);
						else idx_q <= idx_q - NW'(1);
					end else if (idx_q < used_q && trd_s == tq_s) stat_q <= ST_DUP;
					else if (used_q >= NW'(TABLE_DEPTH)) stat_q <= ST_FULL;
					else idx_q <= used_q - NW'(1);
				end
			end
			BK_SCAN_RD: ;
			BK_SHIFT_WR: if (idx_q != pos_q) idx_q <= idx_q - NW'(1);
			BK_NB_WAIT: begin
				// clamp to the last value past the last key
				if (pos_q >= used_q) res_q <= v_rd;
				num_q  <= DW'(signed'(tq_s)) - DW'(signed'(trd_s));
				den_q  <= DW'(t1_q) - DW'(trd_s);
				v0_q   <= signed'(v_rd);
				neg_q  <= v1_q < signed'(v_rd);
				mag_q  <= (v1_q < signed'(v_rd))
					? MW'(signed'(v_rd)) - MW'(v1_q) : MW'(v1_q) - MW'(signed'(v_rd));
				f_q    <= '0;
				step_q <= '0;
			end
			BK_DIV: begin
				if (step_q == 5'd0 && num_q >= den_q) begin
					f_q    <= (FRAC_BITS+1)'(1) << FRAC_BITS;
					step_q <= 5'd16;
				end else if (step_q != 5'd16) begin
					if (rsh >= {1'b0, den_q}) begin
						num_q <= DW'(rsh - {1'b0, den_q});
						f_q   <= {f_q[FRAC_BITS-1:0], 1'b1};
					end else begin
						num_q <= DW'(rsh);
						f_q   <= {f_q[FRAC_BITS-1:0], 1'b0};
					end
					step_q <= step_q + 5'd1;
				end
			end
			BK_MUL_HI: phi_q <= (MW+FRAC_BITS+1)'(f_q) * (MW+FRAC_BITS+1)'(mag_q[MW-1:FRAC_BITS]);
			BK_MUL_LO: plo_q <= (MW+FRAC_BITS+1)'(f_q) * (MW+FRAC_BITS+1)'(mag_q[FRAC_BITS-1:0]);
			BK_ADD: begin
				if (neg_q)
					res_q <= VALUE_WIDTH'(v0_q) - VALUE_WIDTH'(phi_q
						+ (plo_q >> FRAC_BITS) + (MW+FRAC_BITS+1)'(plo_q[FRAC_BITS-1:0] != '0));
				else
					res_q <= VALUE_WIDTH'(v0_q) + VALUE_WIDTH'(phi_q + (plo_q >> FRAC_BITS));
			end
			default: ;
		endcase
	end
endmodule

/* rtl/piecewise_linear_table_interp.sv */
// ----------------------------------------------------------------------------
// piecewise_linear_table_interp
// sorted breakpoint table with clamped fixed point linear interpolation
// ----------------------------------------------------------------------------
// channel | handshake           | payload
// in      | in_valid/in_ready   | cmd, key_time, point_value
// out     | out_valid/out_ready | result_value, status, entry_count
//
// clear empties the table; insert searches entry by entry, then shifts
// the later entries up; an interpolating query searches likewise and passes
// through the queue, the 16-step fraction divider and the split multiply
// the table ram port is the shared resource; one transaction is worked at a time
// a two-entry command queue keeps accepting, until full, while the back end or output stalls
// reset empties the table at once; ram contents need no clearing
module piecewise_linear_table_interp
	import pwl_pkg::*;
#(
	parameter int unsigned TABLE_DEPTH = 64,
	parameter int unsigned TIME_WIDTH  = 32,
	parameter int unsigned VALUE_WIDTH = 32
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  logic [1:0]             cmd,
	input  logic [TIME_WIDTH-1:0]  key_time,
	input  logic [VALUE_WIDTH-1:0] point_value,
	output logic                   out_valid,
	input  logic                   out_ready,
	output logic [VALUE_WIDTH-1:0] result_value,
	output logic [STAT_W-1:0]      status,
	output logic [CNT_W-1:0]       entry_count
);
	// queue between front and back
	logic                   q_valid, q_pop;
	cmd_t                   q_cmd;
	logic [TIME_WIDTH-1:0]  q_time;
	logic [VALUE_WIDTH-1:0] q_value;

	pwl_front #(.TIME_WIDTH(TIME_WIDTH), .VALUE_WIDTH(VALUE_WIDTH)) u_front (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
		.cmd(cmd), .key_time(key_time), .point_value(point_value),
		.q_valid(q_valid), .q_pop(q_pop), .q_cmd(q_cmd), .q_time(q_time),
		.q_value(q_value));

	pwl_back #(.TABLE_DEPTH(TABLE_DEPTH), .TIME_WIDTH(TIME_WIDTH),
		.VALUE_WIDTH(VALUE_WIDTH)) u_back (
		.clk(clk), .arst_n(arst_n), .q_valid(q_valid), .q_pop(q_pop),
		.q_cmd(q_cmd), .q_time(q_time), .q_value(q_value),
		.out_valid(out_valid), .out_ready(out_ready), .result_value(result_value),
		.status(status), .entry_count(entry_count));
endmodule

/* rtl/pwl_checker.sv */
// ----------------------------------------------------------------------------
// pwl_checker
// port level checks of the interpolation table
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module pwl_checker
	import pwl_pkg::*;
(
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_ready,
	input logic [1:0] status,
	input logic [6:0] entry_count
);
	`ASSERT_CLK(a_out_hold, clk, arst_n, out_valid && !out_ready |=> out_valid, "result dropped")
	`ASSERT_CLK(a_cnt_range, clk, arst_n, out_valid |-> entry_count <= 7'd64, "count too big")
	`ASSERT_CLK(a_empty_cnt, clk, arst_n, out_valid && status == ST_EMPTY |-> entry_count == 7'd0, "empty with entries")
	`ASSERT_ALWAYS(a_reset, clk, !arst_n |-> !out_valid, "valid in reset")
endmodule

bind piecewise_linear_table_interp pwl_checker u_chk (
	.clk(clk), .arst_n(arst_n), .out_valid(out_valid), .out_ready(out_ready),
	.status(status), .entry_count(entry_count));
